@@ sv/tsrs_pkg.sv @@
// Shared types, constants and format decode for the texture slot registration block.
package tsrs_pkg;

  // Occupancy table geometry
  localparam int TABLE_SLOTS = 2048;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = (TABLE_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W       = $clog2(NUM_WORDS + 1);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int SLOT_W      = WORD_AW + BIT_W;

  // Source format kinds
  localparam logic [3:0] KIND_1  = 4'd1;
  localparam logic [3:0] KIND_2  = 4'd2;
  localparam logic [3:0] KIND_3  = 4'd3;
  localparam logic [3:0] KIND_4  = 4'd4;
  localparam logic [3:0] KIND_5  = 4'd5;
  localparam logic [3:0] KIND_6  = 4'd6;
  localparam logic [3:0] KIND_7  = 4'd7;
  localparam logic [3:0] KIND_8  = 4'd8;
  localparam logic [3:0] KIND_9  = 4'd9;
  localparam logic [3:0] KIND_10 = 4'd10;

  // Hardware format codes
  localparam logic [5:0] FMT_K1_LIN   = 6'h1d;
  localparam logic [5:0] FMT_K1_SWZ   = 6'h04;
  localparam logic [5:0] FMT_K2_LIN   = 6'h12;
  localparam logic [5:0] FMT_K2_SWZ   = 6'h06;
  localparam logic [5:0] FMT_CMP_HALF = 6'h0c;
  localparam logic [5:0] FMT_CMP_A    = 6'h0e;
  localparam logic [5:0] FMT_CMP_B    = 6'h0f;
  localparam logic [5:0] FMT_K8       = 6'h0b;
  localparam logic [5:0] FMT_WIDE16   = 6'h24;
  localparam logic [5:0] FMT_K10_LIN  = 6'h1e;
  localparam logic [5:0] FMT_K10_SWZ  = 6'h07;
  localparam logic [5:0] FMT_DEF_LIN  = 6'h10;
  localparam logic [5:0] FMT_DEF_SWZ  = 6'h02;

  typedef enum logic [0:0] {T_IDLE, T_BUSY} top_state_e;
  typedef enum logic [1:0] {A_CLEAR, A_IDLE, A_MOD, A_DONE} alloc_state_e;
  typedef enum logic [1:0] {Z_IDLE, Z_MUL, Z_ADD, Z_DONE} sizer_state_e;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [3:0]  kind;
    logic [4:0]  levels;
    logic        lin;
  } tex_req_t;

  typedef struct packed {
    logic        done;
    logic [5:0]  fmt;
    logic [4:0]  levels;
    logic [31:0] bytes;
    logic [16:0] pitch;
    logic        lin;
  } size_rsp_t;

  typedef struct packed {
    logic              ready;
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } slot_rsp_t;

  typedef struct packed {
    logic [5:0] code;
    logic       packed_fmt;
  } fmt_info_t;

  // Format code and block compression from kind and (forced) linear flag
  function automatic fmt_info_t fmt_map(logic [3:0] kind, logic lin);
    fmt_info_t r;
    r.packed_fmt = 1'b0;
    unique case (kind) inside
      KIND_1:         r.code = lin ? FMT_K1_LIN : FMT_K1_SWZ;
      KIND_2:         r.code = lin ? FMT_K2_LIN : FMT_K2_SWZ;
      KIND_3: begin
        r.code       = FMT_CMP_HALF;
        r.packed_fmt = 1'b1;
      end
      KIND_4, KIND_5: begin
        r.code       = FMT_CMP_A;
        r.packed_fmt = 1'b1;
      end
      KIND_6, KIND_7: begin
        r.code       = FMT_CMP_B;
        r.packed_fmt = 1'b1;
      end
      KIND_8:         r.code = FMT_K8;
      KIND_9:         r.code = FMT_WIDE16;
      KIND_10:        r.code = lin ? FMT_K10_LIN : FMT_K10_SWZ;
      default:        r.code = lin ? FMT_DEF_LIN : FMT_DEF_SWZ;
    endcase
    return r;
  endfunction

  // Reset image of one occupancy word: slot 0 and slots past the table read as taken
  function automatic logic [WORD_BITS-1:0] clear_word(logic [WORD_AW-1:0] idx);
    logic [WORD_BITS-1:0] w;
    for (int j = 0; j < WORD_BITS; j++) begin
      w[j] = ((int'(idx) * WORD_BITS + j) >= TABLE_SLOTS) || ((idx == '0) && (j == 0));
    end
    return w;
  endfunction

endpackage

@@ sv/texture_slot_register_and_size.sv @@
// Top level: request handshake, slot claim and sizing control, result register, running total.
//
// Each request claims the lowest free texture slot above slot 0 and sizes its mip chain.
// After reset the occupancy RAM is cleared one 32-slot word per cycle; s_axis_tready
// stays low until that pass ends. For each mip level the sizer does the level-area
// multiply and then the accumulate, while the slot claim (one RAM read, one write back)
// runs alongside. A result waiting in the output register does not hold off the next
// request. slot_index 0 means the table is full; no slot is taken and the running total
// is left as it was, while the other fields still carry the sizing of the request.
module texture_slot_register_and_size
  import tsrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] tex_width, [31:16] tex_height, [36:32] mip_levels, [39:37] zero
  input  logic [39:0]  s_axis_tdata,
  // [3:0] format_kind, [4] linear_request
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [10:0] slot_index, [16:11] format_code, [21:17] levels_used,
  // [53:22] mip_chain_bytes, [70:54] row_pitch, [102:71] total_bytes, [103] zero
  output logic [103:0] m_axis_tdata,
  // [0] linear_flag
  output logic         m_axis_tuser
);

  top_state_e  state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] total_q, total_d;
  logic [10:0] slot_out_q;
  logic [5:0]  fmt_out_q;
  logic [4:0]  lvl_out_q;
  logic [31:0] bytes_out_q;
  logic [16:0] pitch_out_q;
  logic        lin_out_q;

  tex_req_t    req;
  slot_rsp_t   slot_rsp;
  size_rsp_t   size_rsp;
  logic        accept;
  logic        fire;
  logic [31:0] slot_wide;

  assign req.width  = s_axis_tdata[15:0];
  assign req.height = s_axis_tdata[31:16];
  assign req.kind   = s_axis_tuser[3:0];
  assign req.lin    = s_axis_tuser[4];
  assign req.levels = s_axis_tdata[36:32];

  assign s_axis_tready = (state_q == T_IDLE) && slot_rsp.ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tsrs_slot_alloc u_slot_alloc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ack_i   (fire),
    .rsp_o   (slot_rsp)
  );

  tsrs_mip_sizer u_mip_sizer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .req_i   (req),
    .ack_i   (fire),
    .rsp_o   (size_rsp)
  );

  assign slot_wide = 32'(slot_rsp.slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slot_out_q  <= slot_rsp.found ? slot_wide[10:0] : 11'd0;
      fmt_out_q   <= size_rsp.fmt;
      lvl_out_q   <= size_rsp.levels;
      bytes_out_q <= size_rsp.bytes;
      pitch_out_q <= size_rsp.pitch;
      lin_out_q   <= size_rsp.lin;
    end
  end

  always_comb begin
    state_d     = state_q;
    fire        = 1'b0;
    total_d     = total_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          state_d = T_BUSY;
        end
      end
      T_BUSY: begin
        // hand over once both units finish and the result register is free
        if (slot_rsp.done && size_rsp.done && (!out_valid_q || m_axis_tready)) begin
          fire        = 1'b1;
          out_valid_d = 1'b1;
          if (slot_rsp.found) begin
            total_d = total_q + size_rsp.bytes;
          end
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = lin_out_q;
  assign m_axis_tdata  = {1'b0, total_q, pitch_out_q, bytes_out_q, lvl_out_q,
                          fmt_out_q, slot_out_q};

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot_rsp.ready |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_total_held_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !slot_rsp.found |=> total_q == $past(total_q))
    else $error("running total moved without a claimed slot");

  a_fire_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

  a_units_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == T_BUSY) && !slot_rsp.done || slot_rsp.done)
    else $error("slot claim out of step with request");

endmodule

@@ sv/tsrs_ram.sv @@
// Generic single-port RAM with registered read data.
module tsrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tsrs_slot_alloc.sv @@
// Occupancy bitmap in RAM: reset clearing pass and lowest-free-slot claim.
module tsrs_slot_alloc
  import tsrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      ack_i,
  output slot_rsp_t rsp_o
);

  alloc_state_e         state_q, state_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [PTR_W-1:0]     clr_q, clr_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 found_q, found_d;

  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [BIT_W-1:0]     free_idx;
  logic                 free_hit;
  logic [WORD_BITS-1:0] upd_word;

  tsrs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (WORD_AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Lowest clear bit of the word under the pointer
  always_comb begin
    free_idx = '0;
    free_hit = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!free_hit && !ram_rdata[j]) begin
        free_idx = BIT_W'(j);
        free_hit = 1'b1;
      end
    end
    upd_word = ram_rdata | (WORD_BITS'(1) << free_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_CLEAR;
      ptr_q   <= '0;
      clr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    clr_d     = clr_q;
    slot_d    = slot_q;
    found_d   = found_q;
    ram_we    = 1'b0;
    ram_addr  = ptr_q[WORD_AW-1:0];
    ram_wdata = upd_word;
    unique case (state_q)
      A_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q[WORD_AW-1:0];
        ram_wdata = clear_word(clr_q[WORD_AW-1:0]);
        clr_d     = clr_q + PTR_W'(1);
        if (clr_q == PTR_W'(NUM_WORDS - 1)) begin
          state_d = A_IDLE;
        end
      end
      A_IDLE: begin
        if (start_i) begin
          if (ptr_q == PTR_W'(NUM_WORDS)) begin
            found_d = 1'b0;
            state_d = A_DONE;
          end else begin
            state_d = A_MOD;
          end
        end
      end
      A_MOD: begin
        // write back the word with the claimed bit set; step past a full word
        ram_we  = 1'b1;
        slot_d  = {ptr_q[WORD_AW-1:0], free_idx};
        found_d = 1'b1;
        if (&upd_word) begin
          ptr_d = ptr_q + PTR_W'(1);
        end
        state_d = A_DONE;
      end
      A_DONE: begin
        if (ack_i) begin
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  assign rsp_o.ready = (state_q != A_CLEAR);
  assign rsp_o.done  = (state_q == A_DONE);
  assign rsp_o.found = found_q;
  assign rsp_o.slot  = slot_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(NUM_WORDS))
    else $error("word pointer past end of table");

  a_word_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_MOD |-> free_hit)
    else $error("pointed word has no free slot");

  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_DONE && found_q |-> slot_q != '0)
    else $error("slot 0 claimed");

endmodule

@@ sv/tsrs_mip_sizer.sv @@
// Format decode and level-by-level mip chain byte count.
module tsrs_mip_sizer
  import tsrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tex_req_t  req_i,
  input  logic      ack_i,
  output size_rsp_t rsp_o
);

  sizer_state_e state_q, state_d;
  logic [4:0]   rem_q, rem_d;
  logic [15:0]  lw_q, lw_d;
  logic [15:0]  lh_q, lh_d;
  logic [31:0]  prod_q, prod_d;
  logic [31:0]  bytes_q, bytes_d;
  logic [5:0]   fmt_q, fmt_d;
  logic         pk_q, pk_d;
  logic         half_q, half_d;
  logic         quad_q, quad_d;
  logic [4:0]   lvl_q, lvl_d;
  logic [16:0]  pitch_q, pitch_d;
  logic         lin_q, lin_d;

  fmt_info_t    info;
  logic         lin_eff;
  logic [4:0]   lvl_eff;
  logic [15:0]  ew;
  logic [15:0]  eh;
  logic [31:0]  scaled;

  assign lin_eff = req_i.lin || (req_i.kind == KIND_9);
  assign lvl_eff = (req_i.lin || (req_i.levels == '0)) ? 5'd1 : req_i.levels;
  assign info    = fmt_map(req_i.kind, lin_eff);

  // Clamp level dimensions: at least 1, and at least 4 for block formats; scale the product per format
  always_comb begin
    ew = (lw_q == '0) ? 16'd1 : lw_q;
    eh = (lh_q == '0) ? 16'd1 : lh_q;
    if (pk_q && (ew < 16'd4)) ew = 16'd4;
    if (pk_q && (eh < 16'd4)) eh = 16'd4;
    if (pk_q) begin
      scaled = half_q ? (prod_q >> 1) : prod_q;
    end else begin
      scaled = quad_q ? (prod_q << 2) : (prod_q << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Z_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_q    <= lw_d;
    lh_q    <= lh_d;
    prod_q  <= prod_d;
    bytes_q <= bytes_d;
    fmt_q   <= fmt_d;
    pk_q    <= pk_d;
    half_q  <= half_d;
    quad_q  <= quad_d;
    lvl_q   <= lvl_d;
    pitch_q <= pitch_d;
    lin_q   <= lin_d;
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    lw_d    = lw_q;
    lh_d    = lh_q;
    prod_d  = prod_q;
    bytes_d = bytes_q;
    fmt_d   = fmt_q;
    pk_d    = pk_q;
    half_d  = half_q;
    quad_d  = quad_q;
    lvl_d   = lvl_q;
    pitch_d = pitch_q;
    lin_d   = lin_q;
    unique case (state_q)
      Z_IDLE: begin
        if (start_i) begin
          lw_d    = req_i.width;
          lh_d    = req_i.height;
          bytes_d = '0;
          fmt_d   = info.code;
          pk_d    = info.packed_fmt;
          half_d  = (req_i.kind == KIND_3);
          quad_d  = (req_i.kind == KIND_2) || (req_i.kind == KIND_10);
          lvl_d   = lvl_eff;
          rem_d   = lvl_eff;
          pitch_d = (info.code == FMT_WIDE16) ? {req_i.width, 1'b0} : '0;
          lin_d   = lin_eff;
          state_d = Z_MUL;
        end
      end
      Z_MUL: begin
        prod_d  = ew * eh;
        state_d = Z_ADD;
      end
      Z_ADD: begin
        // accumulate this level, halve dimensions for the next
        bytes_d = bytes_q + scaled;
        lw_d    = lw_q >> 1;
        lh_d    = lh_q >> 1;
        rem_d   = rem_q - 5'd1;
        state_d = (rem_q == 5'd1) ? Z_DONE : Z_MUL;
      end
      Z_DONE: begin
        if (ack_i) begin
          state_d = Z_IDLE;
        end
      end
      default: state_d = Z_IDLE;
    endcase
  end

  assign rsp_o.done   = (state_q == Z_DONE);
  assign rsp_o.fmt    = fmt_q;
  assign rsp_o.levels = lvl_q;
  assign rsp_o.bytes  = bytes_q;
  assign rsp_o.pitch  = pitch_q;
  assign rsp_o.lin    = lin_q;

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Z_MUL || state_q == Z_ADD) |-> rem_q != '0)
    else $error("level counter ran out inside the loop");

  a_mul_then_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == Z_MUL |=> state_q == Z_ADD)
    else $error("product not accumulated");

endmodule

@@ bench/tb_texture_slot_register_and_size.sv @@
// Self-checking testbench for texture slot registration and mip-chain sizing.
module tb_texture_slot_register_and_size;
  import tsrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds with no dedicated mapping
  localparam logic [3:0] KIND_UNLISTED_0  = 4'd0;
  localparam logic [3:0] KIND_UNLISTED_11 = 4'd11;
  localparam logic [3:0] KIND_UNLISTED_15 = 4'd15;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 1328;
  localparam int DRAIN_CYCLES  = 80;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [3:0]  kind;
    logic [4:0]  levels;
    logic        lin;
  } tex_request_t;

  typedef struct packed {
    logic [10:0] slot;
    logic [5:0]  fmt;
    logic [4:0]  levels;
    logic [31:0] bytes;
    logic [16:0] pitch;
    logic        lin;
    logic [31:0] total;
  } tex_result_t;

  typedef struct packed {
    tex_request_t req;
    logic         typed;
    tex_result_t  res;
  } directed_row_t;

  // Rows with typed results are the first three after reset; the rest go through the predictor.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{16'd0,     16'd0,     KIND_UNLISTED_0,  5'd0,  1'b0}, 1'b1,
      '{11'd1, FMT_DEF_SWZ,  5'd1, 32'd2,      17'd0,      1'b0, 32'd2}},
    '{'{16'd1,     16'd1,     KIND_3,           5'd31, 1'b1}, 1'b1,
      '{11'd2, FMT_CMP_HALF, 5'd1, 32'd8,      17'd0,      1'b1, 32'd10}},
    '{'{16'd65535, 16'd1,     KIND_9,           5'd0,  1'b0}, 1'b1,
      '{11'd3, FMT_WIDE16,   5'd1, 32'd131070, 17'd131070, 1'b1, 32'd131080}},
    '{'{16'd65535, 16'd65535, KIND_2,           5'd31, 1'b0}, 1'b0, '0},
    '{'{16'd65535, 16'd65535, KIND_10,          5'd1,  1'b1}, 1'b0, '0},
    '{'{16'd256,   16'd128,   KIND_1,           5'd9,  1'b0}, 1'b0, '0},
    '{'{16'd300,   16'd17,    KIND_1,           5'd0,  1'b1}, 1'b0, '0},
    '{'{16'd64,    16'd64,    KIND_2,           5'd7,  1'b1}, 1'b0, '0},
    '{'{16'd1024,  16'd2,     KIND_3,           5'd12, 1'b0}, 1'b0, '0},
    '{'{16'd3,     16'd5,     KIND_4,           5'd4,  1'b0}, 1'b0, '0},
    '{'{16'd65535, 16'd65535, KIND_5,           5'd31, 1'b0}, 1'b0, '0},
    '{'{16'd16,    16'd1,     KIND_6,           5'd5,  1'b1}, 1'b0, '0},
    '{'{16'd7,     16'd9,     KIND_7,           5'd3,  1'b0}, 1'b0, '0},
    '{'{16'd640,   16'd480,   KIND_8,           5'd10, 1'b0}, 1'b0, '0},
    '{'{16'd1,     16'd65535, KIND_8,           5'd2,  1'b1}, 1'b0, '0},
    '{'{16'd32768, 16'd4,     KIND_9,           5'd6,  1'b0}, 1'b0, '0},
    '{'{16'd100,   16'd100,   KIND_9,           5'd6,  1'b1}, 1'b0, '0},
    '{'{16'd512,   16'd512,   KIND_10,          5'd10, 1'b0}, 1'b0, '0},
    '{'{16'd8,     16'd8,     KIND_UNLISTED_11, 5'd4,  1'b0}, 1'b0, '0},
    '{'{16'd65535, 16'd0,     KIND_UNLISTED_15, 5'd16, 1'b0}, 1'b0, '0},
    '{'{16'd0,     16'd65535, KIND_6,           5'd17, 1'b0}, 1'b0, '0},
    '{'{16'd0,     16'd0,     KIND_1,           5'd31, 1'b0}, 1'b0, '0}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         req_valid = 1'b0;
  logic         req_ready;
  // [15:0] tex_width, [31:16] tex_height, [36:32] mip_levels
  logic [39:0]  req_tdata = '0;
  // [3:0] format_kind, [4] linear_request
  logic [4:0]   req_tuser = '0;
  logic         rsp_valid;
  logic         rsp_ready = 1'b0;
  logic [103:0] rsp_tdata;
  logic         rsp_tuser;

  tex_request_t req_on_bus = '0;
  logic         req_typed = 1'b0;
  tex_result_t  req_typed_result = '0;

  tex_result_t  pending_results [$];
  bit           slot_taken [TABLE_SLOTS];
  logic [31:0]  registered_bytes = '0;
  int           mismatch_count = 0;
  int           receiver_hold = 0;
  int           results_seen = 0;

  always #5 clk_i = ~clk_i;

  texture_slot_register_and_size dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (req_ready),
    .s_axis_tdata  (req_tdata),
    .s_axis_tuser  (req_tuser),
    .m_axis_tvalid (rsp_valid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (rsp_tdata),
    .m_axis_tuser  (rsp_tuser)
  );

  // Claim a slot and size the mip chain for one request, updating the occupancy copy.
  function automatic tex_result_t register_texture(tex_request_t r);
    tex_result_t res;
    logic [31:0] lw, lh, area, chain;
    logic [4:0]  count;
    logic        compressed;
    res = '0;
    res.lin = r.lin || (r.kind == KIND_9);
    count = (r.lin || r.levels == 5'd0) ? 5'd1 : r.levels;
    compressed = 1'b0;
    case (r.kind)
      KIND_1:         res.fmt = res.lin ? FMT_K1_LIN : FMT_K1_SWZ;
      KIND_2:         res.fmt = res.lin ? FMT_K2_LIN : FMT_K2_SWZ;
      KIND_3: begin
        res.fmt = FMT_CMP_HALF;
        compressed = 1'b1;
      end
      KIND_4, KIND_5: begin
        res.fmt = FMT_CMP_A;
        compressed = 1'b1;
      end
      KIND_6, KIND_7: begin
        res.fmt = FMT_CMP_B;
        compressed = 1'b1;
      end
      KIND_8:         res.fmt = FMT_K8;
      KIND_9:         res.fmt = FMT_WIDE16;
      KIND_10:        res.fmt = res.lin ? FMT_K10_LIN : FMT_K10_SWZ;
      default:        res.fmt = res.lin ? FMT_DEF_LIN : FMT_DEF_SWZ;
    endcase
    chain = '0;
    for (int l = 0; l < int'(count); l++) begin
      lw = 32'(r.width) >> l;
      lh = 32'(r.height) >> l;
      if (lw == 0) lw = 1;
      if (lh == 0) lh = 1;
      if (compressed) begin
        if (lw < 4) lw = 4;
        if (lh < 4) lh = 4;
        area = lw * lh;
        chain += (r.kind == KIND_3) ? (area >> 1) : area;
      end else begin
        chain += lw * lh * (((r.kind == KIND_2) || (r.kind == KIND_10)) ? 32'd4 : 32'd2);
      end
    end
    res.levels = count;
    res.bytes = chain;
    res.pitch = (res.fmt == FMT_WIDE16) ? {r.width, 1'b0} : 17'd0;
    for (int s = 1; s < TABLE_SLOTS; s++) begin
      if (!slot_taken[s]) begin
        slot_taken[s] = 1'b1;
        res.slot = 11'(s);
        registered_bytes += chain;
        break;
      end
    end
    res.total = registered_bytes;
    return res;
  endfunction

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
  endtask

  // Check results against the oldest expectation, then record the request just accepted.
  always @(posedge clk_i) begin
    tex_result_t got, want;
    if (rsp_valid && rsp_ready) begin
      results_seen++;
      got.slot   = rsp_tdata[10:0];
      got.fmt    = rsp_tdata[16:11];
      got.levels = rsp_tdata[21:17];
      got.bytes  = rsp_tdata[53:22];
      got.pitch  = rsp_tdata[70:54];
      got.total  = rsp_tdata[102:71];
      got.lin    = rsp_tuser;
      if (pending_results.size() == 0) begin
        flag_field("unexpected result, slot_index", '0, 32'(got.slot));
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot) flag_field("slot_index", 32'(want.slot), 32'(got.slot));
        if (got.fmt !== want.fmt) flag_field("format_code", 32'(want.fmt), 32'(got.fmt));
        if (got.levels !== want.levels)
          flag_field("levels_used", 32'(want.levels), 32'(got.levels));
        if (got.bytes !== want.bytes) flag_field("mip_chain_bytes", want.bytes, got.bytes);
        if (got.pitch !== want.pitch) flag_field("row_pitch", 32'(want.pitch), 32'(got.pitch));
        if (got.lin !== want.lin) flag_field("linear_flag", 32'(want.lin), 32'(got.lin));
        if (got.total !== want.total) flag_field("total_bytes", want.total, got.total);
      end
    end
    if (req_valid && req_ready) begin
      want = register_texture(req_on_bus);
      if (req_typed) want = req_typed_result;
      pending_results.push_back(want);
    end
  end

  function automatic logic [15:0] random_extent();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 8));
      1:       return 16'd1 << $urandom_range(0, 15);
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly few levels; a cheap request keeps the chain short.
  function automatic tex_request_t random_texture(bit cheap);
    tex_request_t r;
    r.width  = random_extent();
    r.height = random_extent();
    r.kind   = 4'($urandom_range(0, 15));
    if (cheap)
      r.levels = 5'($urandom_range(0, 3));
    else if ($urandom_range(0, 9) < 7)
      r.levels = 5'($urandom_range(0, 10));
    else
      r.levels = 5'($urandom_range(0, 31));
    r.lin = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // Present one request after an idle gap, optionally waiting until every result is back.
  task automatic send_request(tex_request_t r, logic typed, tex_result_t typed_res,
                              int gap, bit drain_first);
    @(negedge clk_i);
    if (drain_first) begin
      while (pending_results.size() != 0) begin
        req_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid        <= 1'b1;
    req_tdata        <= {3'b000, r.levels, r.height, r.width};
    req_tuser        <= {r.lin, r.kind};
    req_on_bus       <= r;
    req_typed        <= typed;
    req_typed_result <= typed_res;
    do @(posedge clk_i); while (!(req_valid && req_ready));
  endtask

  function automatic int sender_gap(int idx);
    return ((idx / 64) % 4 == 3) ? 0 : $urandom_range(0, 10);
  endfunction

  // Response side: random stalls, full-speed stretches, and one long hold-off on request.
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_hold > 0) begin
        n = receiver_hold;
        receiver_hold = 0;
      end else begin
        n = ((results_seen / 80) % 4 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_valid && rsp_ready));
    end
  end

  initial begin
    int idx;
    int hold_at, drain_at;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idx = 0;
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res, sender_gap(idx), 1'b0);
      idx++;
    end
    hold_at  = $urandom_range(200, 500);
    drain_at = $urandom_range(700, 1000);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == hold_at) receiver_hold = $urandom_range(300, 600);
      send_request(random_texture($urandom_range(0, 3) == 0), 1'b0, '0, sender_gap(idx),
                   k == drain_at);
      idx++;
    end
    @(negedge clk_i);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
